/* rtl/mrs_pkg.sv */
// ----------------------------------------------------------------------------
// mrs_pkg
// shared types, constants and sha-256 helpers for the merkle root block
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam int MaxLeavesDefault = 64;

    typedef struct packed {
        logic [63:0] hash_word;
        logic [1:0]  word_number;
        logic        last_leaf;
    } t_in_item;

    typedef struct packed {
        logic [63:0] root_word;
        logic [1:0]  root_word_number;
        logic        root_last;
        logic        overflow;
    } t_out_item;

    // command from front to back
    typedef struct packed {
        logic [12:0] leaf_count;
        logic        overflow;
    } t_cmd;

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* rtl/mrs_ram.sv */
// ----------------------------------------------------------------------------
// mrs_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module mrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/mrs_sha_core.sv */
// ----------------------------------------------------------------------------
// mrs_sha_core
// one sha-256 compression, one round per cycle
// ----------------------------------------------------------------------------
module mrs_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_digest,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_digest
);
    logic         r_busy;
    logic [5:0]   r_t;
    logic [255:0] r_v;
    logic [255:0] r_h;
    logic [511:0] r_w;
    logic [31:0]  a, b, c, d, e, f, g, h, w, s0, s1, t1, t2, wn;

    assign {a, b, c, d, e, f, g, h} = r_v;
    assign w  = r_w[511:480];
    assign s0 = mrs_pkg::rotr(r_w[479:448], 7) ^ mrs_pkg::rotr(r_w[479:448], 18)
              ^ (r_w[479:448] >> 3);
    assign s1 = mrs_pkg::rotr(r_w[63:32], 17) ^ mrs_pkg::rotr(r_w[63:32], 19)
              ^ (r_w[63:32] >> 10);
    assign wn = s1 + r_w[223:192] + s0 + w;
    assign t1 = h + (mrs_pkg::rotr(e, 6) ^ mrs_pkg::rotr(e, 11) ^ mrs_pkg::rotr(e, 25))
              + ((e & f) ^ (~e & g)) + mrs_pkg::round_k(r_t) + w;
    assign t2 = (mrs_pkg::rotr(a, 2) ^ mrs_pkg::rotr(a, 13) ^ mrs_pkg::rotr(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_t == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_t == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_t <= '0;
            r_v <= i_digest;
            r_h <= i_digest;
            r_w <= i_block;
        end else if (r_busy) begin
            r_t <= r_t + 6'd1;
            r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
            r_w <= {r_w[479:0], wn};
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_digest[i*32 +: 32] = r_h[i*32 +: 32] + r_v[i*32 +: 32];
        end
    end
endmodule

/* rtl/mrs_front.sv */
// ----------------------------------------------------------------------------
// mrs_front
// leaf loading, counting and overflow tracking
// ----------------------------------------------------------------------------
module mrs_front #(
    parameter int MAX_LEAVES = mrs_pkg::MaxLeavesDefault,
    localparam int AW = $clog2(MAX_LEAVES * 4),
    localparam int CW = $clog2(MAX_LEAVES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mrs_pkg::t_in_item i_item,
    input  logic              i_cmd_full,
    output logic              o_ready,
    output logic              o_we,
    output logic [AW-1:0]     o_addr,
    output logic              o_cmd_push,
    output mrs_pkg::t_cmd     o_cmd
);
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          fire, room, w3, last;
    logic [AW+1:0] addr_full;

    assign o_ready   = !i_cmd_full;
    assign fire      = i_valid && o_ready;
    assign room      = r_count < CW'(MAX_LEAVES);
    assign w3        = i_item.word_number == 2'd3;
    assign last      = i_item.last_leaf && w3;
    assign addr_full = (AW + 2)'(r_count) * (AW + 2)'(4) + (AW + 2)'(i_item.word_number);
    assign o_addr    = addr_full[AW-1:0];
    assign o_we      = fire && room;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (fire && w3) begin
            if (room) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        o_cmd_push       = fire && last && (n_count != '0);
        o_cmd.leaf_count = 13'(n_count);
        o_cmd.overflow   = n_ovf;
        if (o_cmd_push) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end
endmodule

/* rtl/mrs_back.sv */
// ----------------------------------------------------------------------------
// mrs_back
// tree builder: pair hashing sequencer over the node store, root output
// ----------------------------------------------------------------------------
module mrs_back #(
    parameter int MAX_LEAVES = mrs_pkg::MaxLeavesDefault,
    localparam int AW = $clog2(MAX_LEAVES * 4),
    localparam int CW = $clog2(MAX_LEAVES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  mrs_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_busy,
    output logic               o_we,
    output logic [AW-1:0]      o_addr,
    output logic [63:0]        o_wdata,
    input  logic [63:0]        i_rdata,
    output logic               o_empty,
    input  logic               i_pop,
    output mrs_pkg::t_out_item o_item
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_C1 = 4'd3,
                           S_W1 = 4'd4, S_C2 = 4'd5, S_W2 = 4'd6, S_WR = 4'd7,
                           S_ORD = 4'd8, S_ORW = 4'd9, S_OUT = 4'd10;

    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_n, r_i;
    logic          r_ovf;
    logic [3:0]    r_k;
    logic [511:0]  r_blk;
    logic [255:0]  r_dig;
    logic          r_start;
    logic [1:0]    r_j;
    logic [63:0]   r_word;
    logic          sha_done;
    logic [255:0]  sha_dig;
    logic [CW:0]   l_idx, r_idx, sel;
    logic [CW:0]   pairs;
    logic          more_pairs;
    logic [AW+3:0] rd_full, wr_full;

    assign l_idx   = {r_i, 1'b0};
    assign r_idx   = ((l_idx + (CW+1)'(1)) < (CW+1)'(r_n)) ? l_idx + (CW+1)'(1) : l_idx;
    assign sel     = r_k[2] ? r_idx : l_idx;
    assign rd_full = (AW+4)'(sel) * (AW+4)'(4) + (AW+4)'(r_k[1:0]);
    assign wr_full = (AW+4)'(r_i) * (AW+4)'(4) + (AW+4)'(r_k[1:0]);
    // node count of the next level, one spare bit so a full level cannot wrap
    assign pairs      = ((CW+1)'(r_n) + (CW+1)'(1)) >> 1;
    assign more_pairs = ((CW+1)'(r_i) + (CW+1)'(1)) < pairs;

    always_comb begin
        o_addr  = rd_full[AW-1:0];
        o_we    = 1'b0;
        o_wdata = r_dig[255 - 64*r_k[1:0] -: 64];
        if (r_st == S_WR) begin
            o_addr = wr_full[AW-1:0];
            o_we   = 1'b1;
        end else if (r_st == S_ORD || r_st == S_ORW || r_st == S_OUT) begin
            o_addr = AW'(r_j);
        end
    end

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign o_busy    = r_st != S_IDLE;
    assign o_empty   = r_st != S_OUT;
    assign o_item    = '{root_word: r_word, root_word_number: r_j,
                         root_last: r_j == 2'd3, overflow: r_ovf};

    mrs_sha_core u_sha (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_digest (r_st == S_C1 ? mrs_pkg::InitH : r_dig),
        .i_block  (r_st == S_C1 ? r_blk : {32'h80000000, 448'd0, 32'd512}),
        .o_done   (sha_done),
        .o_digest (sha_dig)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_cmd_valid) n_st = (13'(i_cmd.leaf_count) > 13'd1) ? S_RD : S_ORD;
            S_RD:   n_st = S_RDW;
            S_RDW:  n_st = (r_k == 4'd7) ? S_C1 : S_RD;
            S_C1:   n_st = S_W1;
            S_W1:   if (sha_done) n_st = S_C2;
            S_C2:   n_st = S_W2;
            S_W2:   if (sha_done) n_st = S_WR;
            S_WR: begin
                if (r_k[1:0] == 2'd3) begin
                    if (more_pairs) begin
                        n_st = S_RD;
                    end else if (pairs > (CW+1)'(1)) begin
                        n_st = S_RD;
                    end else begin
                        n_st = S_ORD;
                    end
                end
            end
            S_ORD:  n_st = S_ORW;
            S_ORW:  n_st = S_OUT;
            S_OUT:  if (i_pop) n_st = (r_j == 2'd3) ? S_IDLE : S_ORD;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_start <= (r_st == S_RDW && r_k == 4'd7) || (r_st == S_W1 && sha_done);
        end
        unique case (r_st)
            S_IDLE: begin
                r_n   <= CW'(i_cmd.leaf_count);
                r_ovf <= i_cmd.overflow;
                r_i   <= '0;
                r_k   <= '0;
                r_j   <= '0;
            end
            S_RDW: begin
                r_blk <= {r_blk[447:0], i_rdata};
                r_k   <= r_k + 4'd1;
            end
            S_W1: if (sha_done) r_dig <= sha_dig;
            S_W2: begin
                if (sha_done) r_dig <= sha_dig;
                r_k <= '0;
            end
            S_WR: begin
                if (r_k[1:0] == 2'd3) begin
                    r_k <= '0;
                    if (more_pairs) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_i <= '0;
                        r_n <= CW'(pairs);
                    end
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end
            S_ORW: r_word <= i_rdata;
            S_OUT: if (i_pop) r_j <= r_j + 2'd1;
            default: ;
        endcase
    end
endmodule

/* rtl/merkle_root_sha256.sv */
// ----------------------------------------------------------------------------
// merkle_root_sha256
// merkle tree root over sha-256 leaf hashes, four 64-bit words per node
// ----------------------------------------------------------------------------
// channel  | direction | handshake      | payload
// input    | in        | i_push, o_full | i_item  (hash word, word number, last)
// result   | out       | o_empty, i_pop | o_item  (root word, number, last, ovf)
//
// a leaf word is taken on each push while o_full is low; the tree build then
// runs 8 store reads (each via S_RD and S_RDW) plus two 64-round compressions
// (each with its start and done) plus 4 writes per pair, one internal node at
// a time in the single round unit; each root word is then fetched via S_ORD, S_ORW
// the input side stalls from the end of a run until its last root word is popped
// reset is synchronous, active low; the node store is not cleared
// ----------------------------------------------------------------------------
module merkle_root_sha256 #(
    parameter int MAX_LEAVES = mrs_pkg::MaxLeavesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  mrs_pkg::t_in_item  i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output mrs_pkg::t_out_item o_item
);
    localparam int AW = $clog2(MAX_LEAVES * 4);

    logic          f_we, b_we, cmd_push, cmd_pop, b_busy;
    logic [AW-1:0] f_addr, b_addr;
    logic [63:0]   b_wdata, rdata;
    mrs_pkg::t_cmd f_cmd, r_cmd;
    logic          r_cmd_valid;
    logic          ready;

    // one-entry run queue between loader and tree builder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (cmd_push) begin
            r_cmd_valid <= 1'b1;
        end else if (cmd_pop) begin
            r_cmd_valid <= 1'b0;
        end
        if (cmd_push) begin
            r_cmd <= f_cmd;
        end
    end

    // loader owns the store port only while the builder is idle
    assign o_full = r_cmd_valid || b_busy;

    mrs_front #(.MAX_LEAVES(MAX_LEAVES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_push),
        .i_item     (i_item),
        .i_cmd_full (o_full),
        .o_ready    (ready),
        .o_we       (f_we),
        .o_addr     (f_addr),
        .o_cmd_push (cmd_push),
        .o_cmd      (f_cmd)
    );

    mrs_back #(.MAX_LEAVES(MAX_LEAVES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (r_cmd_valid),
        .i_cmd       (r_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_busy      (b_busy),
        .o_we        (b_we),
        .o_addr      (b_addr),
        .o_wdata     (b_wdata),
        .i_rdata     (rdata),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_item      (o_item)
    );

    mrs_ram #(.WIDTH(64), .DEPTH(MAX_LEAVES * 4)) u_store (
        .i_clk   (i_clk),
        .i_addr  (f_we ? f_addr : b_addr),
        .i_we    (f_we || b_we),
        .i_wdata (f_we ? i_item.hash_word : b_wdata),
        .o_rdata (rdata)
    );

    // no input accepted while the builder holds the store
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_busy |-> !(ready && i_push)) else $error("input taken while busy");
    // a run command is never overwritten
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_valid |-> !cmd_push) else $error("run command lost");
    // results appear only while the builder is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> b_busy) else $error("result outside a run");
endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for merkle_root_sha256: leaf words go in through the
// push side, an in-bench sha-256 tree builder predicts each root word, and
// every popped word is compared field by field under several idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int LeafCap   = mrs_pkg::MaxLeavesDefault;
    localparam int StoreSize = LeafCap * 4;
    localparam int StallLimit = 200000;

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push  = 1'b0;
    logic               i_pop   = 1'b0;
    mrs_pkg::t_in_item  i_item  = '0;
    logic               o_full;
    logic               o_empty;
    mrs_pkg::t_out_item o_item;

    // predictor state
    logic [63:0]        node_mem [StoreSize];
    int                 leaves_held;
    logic               dropped_leaf;
    mrs_pkg::t_out_item root_words_due [$];

    int errors;
    int idle_cycles;
    int send_gap_pct;
    int pop_stall_pct;

    merkle_root_sha256 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_item  (i_item),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // sha-256 of one 64-byte message: the data block, then the fixed padding block
    function automatic logic [255:0] sha_of_pair(input logic [511:0] msg);
        logic [31:0]  h [8];
        logic [31:0]  v [8];
        logic [31:0]  w [64];
        logic [31:0]  t1;
        logic [31:0]  t2;
        logic [511:0] blk;
        logic [255:0] dig;
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        for (int p = 0; p < 2; p++) begin
            blk = (p == 0) ? msg : {32'h80000000, 448'd0, 32'd512};
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    w[t] = blk[511 - 32 * t -: 32];
                end else begin
                    w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10))
                         + w[t-7]
                         + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                         + w[t-16];
                end
            end
            v = h;
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int k = 0; k < 8; k++) h[k] = h[k] + v[k];
        end
        for (int k = 0; k < 8; k++) dig[255 - 32 * k -: 32] = h[k];
        return dig;
    endfunction

    // in-place tree reduction; odd levels pair the last node with itself
    task automatic reduce_tree();
        int n;
        int pairs;
        int r;
        logic [511:0] msg;
        logic [255:0] dig;
        n = leaves_held;
        while (n > 1) begin
            pairs = (n + 1) / 2;
            for (int i = 0; i < pairs; i++) begin
                r = (2 * i + 1 < n) ? 2 * i + 1 : 2 * i;
                for (int j = 0; j < 4; j++) begin
                    msg[511 - 64 * j -: 64] = node_mem[(2 * i * 4 + j) % StoreSize];
                    msg[255 - 64 * j -: 64] = node_mem[(r * 4 + j) % StoreSize];
                end
                dig = sha_of_pair(msg);
                for (int j = 0; j < 4; j++) node_mem[(i * 4 + j) % StoreSize] = dig[255 - 64 * j -: 64];
            end
            n = pairs;
        end
    endtask

    // apply one accepted item; a last flag on word 3 ends a non-empty run with four root words
    task automatic predict_root(input mrs_pkg::t_in_item it);
        mrs_pkg::t_out_item rw;
        logic               ends_run;
        ends_run = it.last_leaf && (it.word_number == 2'd3);
        if (leaves_held < LeafCap) begin
            node_mem[leaves_held * 4 + it.word_number] = it.hash_word;
            if (it.word_number == 2'd3) leaves_held++;
        end else if (it.word_number == 2'd3) begin
            dropped_leaf = 1'b1;
        end
        if (ends_run && leaves_held != 0) begin
            reduce_tree();
            for (int j = 0; j < 4; j++) begin
                rw.root_word        = node_mem[j];
                rw.root_word_number = j[1:0];
                rw.root_last        = (j == 3);
                rw.overflow         = dropped_leaf;
                root_words_due      = {root_words_due, rw};
            end
            leaves_held  = 0;
            dropped_leaf = 1'b0;
        end
    endtask

    // push holds high across back-to-back items; it only drops during a gap or a drain
    task automatic send_word(input logic [63:0] w, input logic [1:0] num, input logic last);
        mrs_pkg::t_in_item it;
        int gap;
        it = '{hash_word: w, word_number: num, last_leaf: last};
        gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        predict_root(it);
    endtask

    task automatic send_leaf(input logic [255:0] v, input logic last);
        for (int j = 0; j < 4; j++) send_word(v[255 - 64 * j -: 64], j[1:0], last && j == 3);
    endtask

    function automatic logic [255:0] rand_leaf();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic drain_results();
        i_push <= 1'b0;
        wait (root_words_due.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    // full store: every slot gets written, extra leaves are dropped and flagged
    task automatic test_full_store();
        for (int k = 0; k < LeafCap; k++) send_leaf(rand_leaf(), 1'b0);
        send_word(64'hffff_ffff_ffff_ffff, 2'd0, 1'b0);
        send_leaf(rand_leaf(), 1'b0);
        send_leaf(rand_leaf(), 1'b1);
        drain_results();
    endtask

    task automatic test_directed();
        // single leaf is its own root, extremes of the word
        send_leaf({256{1'b1}}, 1'b1);
        send_leaf('0, 1'b1);
        // two leaves, then three so the odd node gets duplicated
        send_leaf({4{64'h0123_4567_89ab_cdef}}, 1'b0);
        send_leaf({4{64'hfedc_ba98_7654_3210}}, 1'b1);
        send_leaf(rand_leaf(), 1'b0);
        send_leaf(rand_leaf(), 1'b0);
        send_leaf(rand_leaf(), 1'b1);
        // last flag on words 0-2 is ignored, and a leaf with missing words
        // reuses what its slot held
        send_word(64'h8000_0000_0000_0001, 2'd0, 1'b1);
        send_word(64'h7fff_ffff_ffff_fffe, 2'd2, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 2'd3, 1'b0);
        send_word(64'h0, 2'd3, 1'b1);
        drain_results();
    endtask

    // mostly well-formed runs of random leaves, some reordered or broken leaves
    task automatic test_random(input int gap_pct, input int stall_pct, input int words);
        int sent;
        int n;
        int kind;
        logic [255:0] v;
        send_gap_pct  = gap_pct;
        pop_stall_pct = stall_pct;
        sent = 0;
        while (sent < words) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                v = rand_leaf();
                kind = $urandom_range(9);
                if (kind == 0) begin
                    // partial leaf: only some words, word 3 always closes it
                    for (int j = 0; j < 3; j++)
                        if ($urandom_range(1)) send_word(v[255 - 64 * j -: 64], j[1:0], $urandom_range(1));
                    send_word(v[63:0], 2'd3, k == n - 1);
                    sent += 2;
                end else if (kind == 1) begin
                    // words out of order with stray last flags on the early ones
                    send_word(v[127:64], 2'd2, $urandom_range(1));
                    send_word(v[255:192], 2'd0, $urandom_range(1));
                    send_word(v[191:128], 2'd1, $urandom_range(1));
                    send_word(v[63:0], 2'd3, k == n - 1);
                    sent += 4;
                end else begin
                    send_leaf(v, k == n - 1);
                    sent += 4;
                end
            end
        end
        drain_results();
    endtask

    // result checking, receiver stalls and the no-progress watchdog
    always @(posedge i_clk) begin
        mrs_pkg::t_out_item want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (root_words_due.size() == 0) begin
                $error("unexpected root word %h", o_item.root_word);
                errors++;
            end else begin
                want = root_words_due.pop_front();
                if (o_item.root_word !== want.root_word) begin
                    $error("root_word expected %h got %h", want.root_word, o_item.root_word);
                    errors++;
                end
                if (o_item.root_word_number !== want.root_word_number) begin
                    $error("root_word_number expected %0d got %0d",
                           want.root_word_number, o_item.root_word_number);
                    errors++;
                end
                if (o_item.root_last !== want.root_last) begin
                    $error("root_last expected %b got %b", want.root_last, o_item.root_last);
                    errors++;
                end
                if (o_item.overflow !== want.overflow) begin
                    $error("overflow expected %b got %b", want.overflow, o_item.overflow);
                    errors++;
                end
            end
        end
        if ((i_pop && !o_empty) || (i_push && !o_full)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("merkle_root_sha256 verification failed");
            $finish;
        end
        i_pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    initial begin
        errors        = 0;
        idle_cycles   = 0;
        leaves_held   = 0;
        dropped_leaf  = 1'b0;
        send_gap_pct  = 0;
        pop_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_store();
        test_directed();
        test_random(0, 0, 40);
        test_random(82, 0, 40);
        test_random(0, 82, 40);
        test_random(34, 34, 40);

        if (errors == 0) $display("merkle_root_sha256 verification clean");
        else $display("merkle_root_sha256 verification failed");
        $finish;
    end

endmodule
